@@ rtl/core/slid_pkg.sv @@
// Shared types, constants and codes for the sorted insertion list.
`default_nettype none

package slid_pkg;

  // Store size and derived widths
  localparam int DEPTH = 16;
  localparam int CNT_W = $clog2(DEPTH + 1);

  // Field widths fixed by the interface
  localparam int FUNC_W  = 2;
  localparam int WORD_W  = 32;
  localparam int INDEX_W = 4;
  localparam int STAT_W  = 2;
  localparam int COUNT_W = 5;

  // Queue sizing shared by the command queue and the result queue
  localparam int Q_DEPTH = 2;
  localparam int Q_PTR_W = $clog2(Q_DEPTH);
  localparam int Q_CNT_W = $clog2(Q_DEPTH + 1);

  // Input function codes
  localparam logic [FUNC_W-1:0] FN_INS = 2'd0;
  localparam logic [FUNC_W-1:0] FN_DEL = 2'd1;
  localparam logic [FUNC_W-1:0] FN_RD  = 2'd2;

  // Internal operation classes
  localparam logic [1:0] OP_INS = 2'd0;
  localparam logic [1:0] OP_DEL = 2'd1;
  localparam logic [1:0] OP_RD  = 2'd2;
  localparam logic [1:0] OP_NOP = 2'd3;

  // Result status codes
  localparam logic [STAT_W-1:0] ST_OK        = 2'd0;
  localparam logic [STAT_W-1:0] ST_FULL      = 2'd1;
  localparam logic [STAT_W-1:0] ST_NOT_FOUND = 2'd2;
  localparam logic [STAT_W-1:0] ST_BAD_INDEX = 2'd3;

  typedef logic signed [WORD_W-1:0] word_t;

  typedef struct packed {
    logic [FUNC_W-1:0]        func;
    logic signed [WORD_W-1:0] value;
    logic [INDEX_W-1:0]       index;
  } in_item_t;

  typedef struct packed {
    logic [STAT_W-1:0]        status;
    logic [COUNT_W-1:0]       count;
    logic signed [WORD_W-1:0] read_value;
  } out_item_t;

  typedef struct packed {
    logic [1:0]               op;
    logic signed [WORD_W-1:0] value;
    logic [INDEX_W-1:0]       index;
  } cmd_t;

  // Head of the command queue as seen by the back end
  typedef struct packed {
    logic valid;
    cmd_t cmd;
  } cmd_chan_t;

  // Result transfer from the back end into the result queue
  typedef struct packed {
    logic      push;
    out_item_t item;
  } res_chan_t;

endpackage

`default_nettype wire

@@ rtl/core/slid_front.sv @@
// Front end: accepts input items, decodes the function and queues commands.
`default_nettype none

module slid_front (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               in_push,
  output logic                    in_full,
  input  wire slid_pkg::in_item_t in_item,
  output slid_pkg::cmd_chan_t     cmd_chan,
  input  wire logic               cmd_pop
);
  import slid_pkg::*;

  cmd_t               q_r [Q_DEPTH];
  logic [Q_PTR_W-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [Q_PTR_W-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [Q_CNT_W-1:0] cnt_r, cnt_nxt;
  logic               push_ok;
  logic               pop_ok;
  cmd_t               cmd_in;

  // Classify the incoming function; the unused code becomes a no-op
  always_comb begin
    cmd_in.value = in_item.value;
    cmd_in.index = in_item.index;
    case (in_item.func)
      FN_INS:  cmd_in.op = OP_INS;
      FN_DEL:  cmd_in.op = OP_DEL;
      FN_RD:   cmd_in.op = OP_RD;
      default: cmd_in.op = OP_NOP;
    endcase
  end

  // Queue bookkeeping
  always_comb begin
    in_full    = (cnt_r == Q_CNT_W'(Q_DEPTH));
    push_ok    = in_push && !in_full;
    pop_ok     = cmd_pop && (cnt_r != '0);
    wr_ptr_nxt = push_ok ? wr_ptr_r + Q_PTR_W'(1) : wr_ptr_r;
    rd_ptr_nxt = pop_ok ? rd_ptr_r + Q_PTR_W'(1) : rd_ptr_r;
    cnt_nxt    = cnt_r;
    if (push_ok && !pop_ok) begin
      cnt_nxt = cnt_r + Q_CNT_W'(1);
    end else if (pop_ok && !push_ok) begin
      cnt_nxt = cnt_r - Q_CNT_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  // Queue storage
  always_ff @(posedge clk) begin
    if (push_ok) begin
      q_r[wr_ptr_r] <= cmd_in;
    end
  end

  assign cmd_chan.valid = (cnt_r != '0);
  assign cmd_chan.cmd   = q_r[rd_ptr_r];

`ifndef SYNTHESIS
  a_cnt_bound: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r <= Q_CNT_W'(Q_DEPTH))
    else $error("command queue count out of range");
  a_ptr_gap: assert property (@(posedge clk) disable iff (!rst_n)
    (cnt_r == '0 || cnt_r == Q_CNT_W'(Q_DEPTH)) |-> (wr_ptr_r == rd_ptr_r))
    else $error("command queue pointers disagree with count");
  a_push_full: assert property (@(posedge clk) disable iff (!rst_n)
    (in_push && in_full) |=> (cnt_r == $past(cnt_r) || cnt_r == $past(cnt_r) - Q_CNT_W'(1)))
    else $error("command queue grew while full");
`endif

endmodule

`default_nettype wire

@@ rtl/core/slid_back.sv @@
// Back end: sorted cell array with parallel compare and one-step shift update.
`default_nettype none

module slid_back (
  input  wire logic                clk,
  input  wire logic                rst_n,
  input  wire slid_pkg::cmd_chan_t cmd_chan,
  output logic                     cmd_pop,
  input  wire logic                oq_full,
  output slid_pkg::res_chan_t      res_chan
);
  import slid_pkg::*;

  localparam logic S_IDLE = 1'b0;
  localparam logic S_EXEC = 1'b1;

  logic               state_r, state_nxt;
  logic [1:0]         op_r;
  word_t              val_r;
  logic [INDEX_W-1:0] idx_r;
  logic [DEPTH-1:0]   lt_r, lt_nxt;
  logic [DEPTH-1:0]   eq_r, eq_nxt;
  word_t              ent_r [DEPTH];
  word_t              ent_nxt [DEPTH];
  logic [CNT_W-1:0]   cnt_r, cnt_nxt;

  logic [DEPTH-1:0]   valid_v;
  logic [DEPTH-1:0]   at_after;
  logic [DEPTH-1:0]   hit;
  logic [DEPTH-1:0]   del_after;
  logic               found;
  logic               is_full;
  logic               rd_ok;
  logic               commit;
  logic [STAT_W-1:0]  status;
  word_t              rd_val;

  // Compare stage: every cell against the head command's value
  always_comb begin
    for (int i = 0; i < DEPTH; i++) begin
      lt_nxt[i] = ent_r[i] < cmd_chan.cmd.value;
      eq_nxt[i] = ent_r[i] == cmd_chan.cmd.value;
    end
  end

  assign cmd_pop = (state_r == S_IDLE) && cmd_chan.valid;
  assign commit  = (state_r == S_EXEC) && !oq_full;

  always_comb begin
    state_nxt = state_r;
    if (cmd_pop) begin
      state_nxt = S_EXEC;
    end else if (commit) begin
      state_nxt = S_IDLE;
    end
  end

  // Position masks from the registered compare results
  always_comb begin
    for (int i = 0; i < DEPTH; i++) begin
      valid_v[i]  = CNT_W'(i) < cnt_r;
      at_after[i] = !(valid_v[i] && lt_r[i]);
      hit[i]      = valid_v[i] && eq_r[i];
    end
    for (int i = 0; i < DEPTH; i++) begin
      del_after[i] = 1'b0;
      for (int j = 0; j < DEPTH; j++) begin
        if (j <= i) begin
          del_after[i] = del_after[i] | hit[j];
        end
      end
    end
    found   = |hit;
    is_full = (cnt_r == CNT_W'(DEPTH));
    rd_ok   = ({1'b0, idx_r} < (INDEX_W + 1)'(cnt_r)) || (cnt_r > CNT_W'((1 << INDEX_W) - 1));
    rd_val  = ent_r[idx_r];
  end

  // Update step: shift up behind the insert point or down over the deleted cell, and set the status
  always_comb begin
    for (int i = 0; i < DEPTH; i++) begin
      ent_nxt[i] = ent_r[i];
    end
    cnt_nxt = cnt_r;
    status  = ST_OK;
    case (op_r)
      OP_INS: begin
        if (is_full) begin
          status = ST_FULL;
        end else begin
          cnt_nxt = cnt_r + CNT_W'(1);
          ent_nxt[0] = at_after[0] ? val_r : ent_r[0];
          for (int i = 1; i < DEPTH; i++) begin
            if (at_after[i]) begin
              ent_nxt[i] = at_after[i-1] ? ent_r[i-1] : val_r;
            end
          end
        end
      end
      OP_DEL: begin
        if (!found) begin
          status = ST_NOT_FOUND;
        end else begin
          cnt_nxt = cnt_r - CNT_W'(1);
          for (int i = 0; i < DEPTH - 1; i++) begin
            if (del_after[i]) begin
              ent_nxt[i] = ent_r[i+1];
            end
          end
        end
      end
      OP_RD: begin
        if (!rd_ok) begin
          status = ST_BAD_INDEX;
        end
      end
      default: begin
        status = ST_OK;
      end
    endcase
  end

  assign res_chan.push             = commit;
  assign res_chan.item.status      = status;
  assign res_chan.item.count       = COUNT_W'(cnt_nxt);
  assign res_chan.item.read_value  = (op_r == OP_RD && rd_ok) ? rd_val : '0;

  // Control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      cnt_r   <= '0;
    end else begin
      state_r <= state_nxt;
      if (commit) begin
        cnt_r <= cnt_nxt;
      end
    end
  end

  // Command capture and cell storage
  always_ff @(posedge clk) begin
    if (cmd_pop) begin
      op_r  <= cmd_chan.cmd.op;
      val_r <= cmd_chan.cmd.value;
      idx_r <= cmd_chan.cmd.index;
      lt_r  <= lt_nxt;
      eq_r  <= eq_nxt;
    end
    if (commit) begin
      for (int i = 0; i < DEPTH; i++) begin
        ent_r[i] <= ent_nxt[i];
      end
    end
  end

`ifndef SYNTHESIS
  a_cnt_bound: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r <= CNT_W'(DEPTH))
    else $error("entry count beyond store depth");
  a_pop_exec: assert property (@(posedge clk) disable iff (!rst_n)
    cmd_pop |=> (state_r == S_EXEC))
    else $error("command taken without entering execute");
  a_no_overrun: assert property (@(posedge clk) disable iff (!rst_n)
    res_chan.push |-> !oq_full)
    else $error("result pushed into full queue");
  a_ins_count: assert property (@(posedge clk) disable iff (!rst_n)
    (commit && op_r == OP_INS && status == ST_OK) |=> (cnt_r == $past(cnt_r) + CNT_W'(1)))
    else $error("insert did not raise the count");
  a_del_count: assert property (@(posedge clk) disable iff (!rst_n)
    (commit && op_r == OP_DEL && status == ST_OK) |=> (cnt_r == $past(cnt_r) - CNT_W'(1)))
    else $error("delete did not lower the count");
`endif

endmodule

`default_nettype wire

@@ rtl/core/slid_outq.sv @@
// Result queue: holds finished results until the consumer takes them.
`default_nettype none

module slid_outq (
  input  wire logic                clk,
  input  wire logic                rst_n,
  input  wire slid_pkg::res_chan_t res_chan,
  output logic                     oq_full,
  output logic                     out_empty,
  input  wire logic                out_pop,
  output slid_pkg::out_item_t      out_item
);
  import slid_pkg::*;

  out_item_t          q_r [Q_DEPTH];
  logic [Q_PTR_W-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [Q_PTR_W-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [Q_CNT_W-1:0] cnt_r, cnt_nxt;
  logic               push_ok;
  logic               pop_ok;

  // Pointer and fill tracking
  always_comb begin
    oq_full    = (cnt_r == Q_CNT_W'(Q_DEPTH));
    out_empty  = (cnt_r == '0);
    push_ok    = res_chan.push && !oq_full;
    pop_ok     = out_pop && !out_empty;
    wr_ptr_nxt = push_ok ? wr_ptr_r + Q_PTR_W'(1) : wr_ptr_r;
    rd_ptr_nxt = pop_ok ? rd_ptr_r + Q_PTR_W'(1) : rd_ptr_r;
    cnt_nxt    = cnt_r;
    if (push_ok && !pop_ok) begin
      cnt_nxt = cnt_r + Q_CNT_W'(1);
    end else if (pop_ok && !push_ok) begin
      cnt_nxt = cnt_r - Q_CNT_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push_ok) begin
      q_r[wr_ptr_r] <= res_chan.item;
    end
  end

  assign out_item = q_r[rd_ptr_r];

`ifndef SYNTHESIS
  a_cnt_bound: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r <= Q_CNT_W'(Q_DEPTH))
    else $error("result queue count out of range");
  a_ptr_gap: assert property (@(posedge clk) disable iff (!rst_n)
    (cnt_r == '0 || cnt_r == Q_CNT_W'(Q_DEPTH)) |-> (wr_ptr_r == rd_ptr_r))
    else $error("result queue pointers disagree with count");
  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (!out_empty && !out_pop) |=> $stable(out_item))
    else $error("waiting result changed before transfer");
`endif

endmodule

`default_nettype wire

@@ rtl/core/sorted_list_insert_delete.sv @@
// Top level of the sorted insertion list: front end, back end and result queue.
//
// Keeps up to 16 signed 32-bit values in ascending order. Insert places a value
// ahead of any equal values; delete removes the first equal value; read returns
// the entry at an index. Every item yields one result with status and count.
// In the back end the value is compared against all cells in parallel and the
// results registered as the item is taken; the execute state then shifts the
// cells and writes the result, holding while the result queue is full. A new
// item is taken only after the previous result is written. A two-entry command
// queue lets new items be taken while the back end works, and a two-entry result
// queue lets it finish while earlier results wait. A result passes through the
// command queue, the back end and the result queue before it can be taken, and
// waits longer while earlier items are still in the back end or command queue.
// Entries are undefined after reset; only those below the count reach a result.
`default_nettype none

module sorted_list_insert_delete (
  input  wire logic                clk,
  input  wire logic                rst_n,
  input  wire logic                in_push,
  output logic                     in_full,
  input  wire slid_pkg::in_item_t  in_item,
  output logic                     out_empty,
  input  wire logic                out_pop,
  output slid_pkg::out_item_t      out_item
);
  import slid_pkg::*;

  cmd_chan_t cmd_chan;
  logic      cmd_pop;
  res_chan_t res_chan;
  logic      oq_full;

  slid_front u_front (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_push  (in_push),
    .in_full  (in_full),
    .in_item  (in_item),
    .cmd_chan (cmd_chan),
    .cmd_pop  (cmd_pop)
  );

  slid_back u_back (
    .clk      (clk),
    .rst_n    (rst_n),
    .cmd_chan (cmd_chan),
    .cmd_pop  (cmd_pop),
    .oq_full  (oq_full),
    .res_chan (res_chan)
  );

  slid_outq u_outq (
    .clk       (clk),
    .rst_n     (rst_n),
    .res_chan  (res_chan),
    .oq_full   (oq_full),
    .out_empty (out_empty),
    .out_pop   (out_pop),
    .out_item  (out_item)
  );

endmodule

`default_nettype wire

@@ verif/slid_checker.sv @@
`timescale 1ns / 1ps
// Checker for the sorted insertion list: predicts every result and compares it on transfer.
module slid_checker (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_push,
  input  logic                in_full,
  input  slid_pkg::in_item_t  in_item,
  input  logic                out_empty,
  input  logic                out_pop,
  input  slid_pkg::out_item_t out_item,
  output int                  fails,
  output int                  pending,
  output int                  checked,
  output int                  full_refusals,
  output int                  misses,
  output int                  index_faults
);

  localparam int SHOWN_MAX = 10;

  // Shadow of the store, ascending, plus the results still owed by the block
  slid_pkg::word_t     shadow [slid_pkg::DEPTH];
  int                  shadow_n;
  slid_pkg::out_item_t owed_q [$];

  // Apply one operation to the shadow store and work out its result
  function automatic slid_pkg::out_item_t apply_op(input slid_pkg::in_item_t it);
    slid_pkg::out_item_t res;
    slid_pkg::word_t     v;
    int                  pos;
    int                  i;
    v          = it.value;
    res        = '0;
    res.status = slid_pkg::ST_OK;
    pos        = 0;
    case (it.func)
      slid_pkg::FN_INS: begin
        if (shadow_n >= slid_pkg::DEPTH) begin
          res.status = slid_pkg::ST_FULL;
        end else begin
          // new value goes ahead of any equal ones
          while (pos < shadow_n && shadow[pos] < v) pos++;
          for (i = shadow_n; i > pos; i--) shadow[i] = shadow[i-1];
          shadow[pos] = v;
          shadow_n++;
        end
      end
      slid_pkg::FN_DEL: begin
        while (pos < shadow_n && shadow[pos] != v) pos++;
        if (pos >= shadow_n) begin
          res.status = slid_pkg::ST_NOT_FOUND;
        end else begin
          for (i = pos; i + 1 < shadow_n; i++) shadow[i] = shadow[i+1];
          shadow_n--;
        end
      end
      slid_pkg::FN_RD: begin
        if (int'(it.index) < shadow_n) begin
          res.read_value = shadow[it.index];
        end else begin
          res.status = slid_pkg::ST_BAD_INDEX;
        end
      end
      default: ; // spare code: no change, plain ok
    endcase
    res.count = slid_pkg::COUNT_W'(shadow_n);
    return res;
  endfunction

  // Predict on input transfers, compare on result transfers
  always @(posedge clk) begin
    slid_pkg::out_item_t want;
    bit                  bad;
    if (!rst_n) begin
      shadow_n      = 0;
      owed_q.delete();
      fails         = 0;
      pending       = 0;
      checked       = 0;
      full_refusals = 0;
      misses        = 0;
      index_faults  = 0;
    end else begin
      if (in_push && !in_full) owed_q.push_back(apply_op(in_item));
      if (out_pop && !out_empty) begin
        if (owed_q.size() == 0) begin
          fails++;
          if (fails <= SHOWN_MAX)
            $display("%0t: result with none owed: status=%0d count=%0d value=%0d", $time,
                     out_item.status, out_item.count, $signed(out_item.read_value));
        end else begin
          want = owed_q.pop_front();
          checked++;
          bad = (out_item.status !== want.status) || (out_item.count !== want.count) ||
                (out_item.read_value !== want.read_value);
          if (bad) begin
            fails++;
            if (fails <= SHOWN_MAX)
              $display("%0t: mismatch: expected status=%0d count=%0d value=%0d,",
                       $time, want.status, want.count, $signed(want.read_value),
                       " got status=%0d count=%0d value=%0d",
                       out_item.status, out_item.count, $signed(out_item.read_value));
          end
          case (want.status)
            slid_pkg::ST_FULL:      full_refusals++;
            slid_pkg::ST_NOT_FOUND: misses++;
            slid_pkg::ST_BAD_INDEX: index_faults++;
            default: ;
          endcase
        end
      end
      pending = owed_q.size();
    end
  end

endmodule

@@ verif/tb_sorted_list_insert_delete.sv @@
`timescale 1ns / 1ps
// Testbench top for the sorted insertion list: stimulus, result pacing and verdict.
module tb_sorted_list_insert_delete;
  import slid_pkg::*;

  localparam int PHASE_ITEMS = 375;
  localparam int HOLD_CYCLES = 300;
  localparam int CYCLE_LIMIT = 200000;
  localparam int POOL_MAX    = 24;
  localparam logic [FUNC_W-1:0] FN_SPARE = 2'd3;

  logic      clk = 1'b0;
  logic      rst_n;
  logic      in_push;
  logic      in_full;
  in_item_t  in_item;
  logic      out_empty;
  logic      out_pop;
  out_item_t out_item;

  int fails, pending, checked, full_refusals, misses, index_faults;
  int send_idle_pct = 8;
  int recv_idle_pct = 63;
  bit hold_go = 1'b0;
  int sent = 0;
  int cycles = 0;
  word_t recent [$];

  // 100 MHz clock
  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  sorted_list_insert_delete i_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_push   (in_push),
    .in_full   (in_full),
    .in_item   (in_item),
    .out_empty (out_empty),
    .out_pop   (out_pop),
    .out_item  (out_item)
  );

  slid_checker i_check (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_push       (in_push),
    .in_full       (in_full),
    .in_item       (in_item),
    .out_empty     (out_empty),
    .out_pop       (out_pop),
    .out_item      (out_item),
    .fails         (fails),
    .pending       (pending),
    .checked       (checked),
    .full_refusals (full_refusals),
    .misses        (misses),
    .index_faults  (index_faults)
  );

  // Watchdog
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles == CYCLE_LIMIT) begin
      $display("tb_sorted_list_insert_delete: done, errors");
      $finish;
    end
  end

  // Result side: random pops, or one long hold-off when asked
  initial begin
    out_pop = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_go) begin
        hold_go = 1'b0;
        out_pop <= 1'b0;
        repeat (HOLD_CYCLES) @(negedge clk);
      end else begin
        out_pop <= ($urandom_range(0, 99) >= recv_idle_pct);
      end
    end
  end

  // Offer one item with random gaps ahead of it and wait for its transfer
  task automatic send(input logic [FUNC_W-1:0] f, input word_t v, input logic [INDEX_W-1:0] idx);
    while ($urandom_range(0, 99) < send_idle_pct) begin
      in_push <= 1'b0;
      @(negedge clk);
    end
    in_item <= '{func: f, value: v, index: idx};
    in_push <= 1'b1;
    do @(posedge clk); while (in_full);
    @(negedge clk);
    sent++;
    if (f == FN_INS) begin
      recent.push_back(v);
      if (recent.size() > POOL_MAX) recent.delete(0);
    end
  endtask

  // Change pacing away from the sampling edge; optionally start the long stall
  task automatic set_pacing(input int sidle, input int ridle, input bit hold);
    in_push <= 1'b0;
    @(posedge clk);
    send_idle_pct = sidle;
    recv_idle_pct = ridle;
    if (hold) hold_go = 1'b1;
    @(negedge clk);
  endtask

  // Small values and recent inserts give duplicates and delete hits
  function automatic word_t pick_value();
    int r;
    r = $urandom_range(0, 9);
    if (r < 3) return word_t'($urandom_range(0, 8)) - word_t'(4);
    if (r < 6 && recent.size() > 0) return recent[$urandom_range(0, recent.size() - 1)];
    if (r == 6) return $urandom_range(0, 1) ? 32'sh7fffffff : 32'sh80000000;
    return word_t'($urandom);
  endfunction

  // Random traffic, switching at random between filling and draining the store
  task automatic run_phase(input int sidle, input int ridle, input bit with_hold);
    int k;
    int r;
    bit filling;
    filling = 1'b1;
    set_pacing(sidle, ridle, 1'b0);
    for (k = 0; k < PHASE_ITEMS; k++) begin
      if (with_hold && k == 20) set_pacing(sidle, ridle, 1'b1);
      if (k % 40 == 0) filling = $urandom_range(0, 1);
      r = $urandom_range(0, 99);
      if (r < (filling ? 60 : 20))
        send(FN_INS, pick_value(), 4'($urandom_range(0, 15)));
      else if (r < 75)
        send(FN_DEL, pick_value(), 4'($urandom_range(0, 15)));
      else if (r < 97)
        send(FN_RD, word_t'($urandom), 4'($urandom_range(0, 15)));
      else
        send(FN_SPARE, word_t'($urandom), 4'($urandom_range(0, 15)));
    end
  endtask

  initial begin
    rst_n   = 1'b0;
    in_push = 1'b0;
    in_item = '0;
    repeat (8) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    set_pacing(8, 63, 1'b0);

    // Directed: empty store, fill to the top with extremes and duplicates, edges
    send(FN_SPARE, 32'sh5a5a5a5a, 4'd0);
    send(FN_RD, 32'sd0, 4'd0);
    send(FN_DEL, 32'sd5, 4'd0);
    send(FN_INS, 32'sh7fffffff, 4'd0);
    send(FN_INS, 32'sh80000000, 4'd0);
    send(FN_INS, 32'sd0, 4'd0);
    send(FN_INS, 32'sd0, 4'd0);
    send(FN_INS, -32'sd1, 4'd0);
    send(FN_INS, 32'sd1, 4'd0);
    send(FN_INS, 32'sd7, 4'd0);
    send(FN_INS, 32'sd7, 4'd0);
    send(FN_INS, -32'sd7, 4'd0);
    send(FN_INS, 32'sd100, 4'd0);
    send(FN_INS, -32'sd100, 4'd0);
    send(FN_INS, 32'sh7ffffffe, 4'd0);
    send(FN_INS, 32'sh80000001, 4'd0);
    send(FN_INS, 32'sd3, 4'd0);
    send(FN_INS, 32'sd3, 4'd0);
    send(FN_INS, 32'sd42, 4'd0);
    send(FN_INS, 32'sd9, 4'd0);         // store full: refused
    send(FN_RD, 32'sd0, 4'd0);
    send(FN_RD, 32'sd0, 4'd15);
    send(FN_DEL, 32'sh7fffffff, 4'd0);
    send(FN_DEL, 32'sh80000000, 4'd0);
    send(FN_DEL, 32'sd12345, 4'd0);     // absent value

    run_phase(8, 63, 1'b0);
    run_phase(63, 8, 1'b0);
    run_phase(0, 0, 1'b1);
    in_push <= 1'b0;

    // Drain, then keep watching for anything stray
    while (pending != 0) @(negedge clk);
    repeat (20) @(negedge clk);

    $display("Covered %0d input transfers and %0d checked results over three pacing phases,",
             sent, checked);
    $display("one long result stall; %0d full refusals, %0d values not found, %0d index faults.",
             full_refusals, misses, index_faults);
    if (fails == 0 && pending == 0) begin
      $display("tb_sorted_list_insert_delete: done, clean");
    end else begin
      $display("tb_sorted_list_insert_delete: done, errors");
    end
    $finish;
  end

endmodule
